// ----- sv/ims_pkg.sv -----
// Shared types and constants of the Ising Metropolis spin update block.
`default_nettype none
package ims_pkg;

  localparam int SIDE_DEF      = 64;
  localparam int ROLL_BITS_DEF = 24;

  localparam int IN_CRD_W    = 6;
  localparam int CRD_W       = 7;
  localparam int SIDE_W      = 7;
  localparam int WEIGHT_W    = 24;
  localparam int ROLL_W      = 24;
  localparam int MAG_W       = 14;
  localparam int LP_W        = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int STEP_W      = 3;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;
  localparam int PROD_W      = 2 * WEIGHT_W;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CW_M4 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CW_M2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CW_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CW_P2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CW_P4 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FW_DN = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FW_UP = 3'd7;

  localparam logic [SIDE_W-1:0]   SIDE_RST   = 7'd64;
  localparam logic [SIDE_W-1:0]   SIDE_MIN   = 7'd2;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 24'd65536;

  localparam logic [STEP_W-1:0] MOD_LAST  = 3'd5;
  localparam logic [STEP_W-1:0] WRAP_LAST = 3'd3;
  localparam logic [STEP_W-1:0] READ_LAST = 3'd5;

  // neighbour wrap steps
  localparam logic [STEP_W-1:0] WR_UP    = 3'd0;
  localparam logic [STEP_W-1:0] WR_DOWN  = 3'd1;
  localparam logic [STEP_W-1:0] WR_RIGHT = 3'd2;
  localparam logic [STEP_W-1:0] WR_LEFT  = 3'd3;

  // read issue steps
  localparam logic [STEP_W-1:0] RD_CENTER = 3'd0;
  localparam logic [STEP_W-1:0] RD_UP     = 3'd1;
  localparam logic [STEP_W-1:0] RD_DOWN   = 3'd2;
  localparam logic [STEP_W-1:0] RD_LEFT   = 3'd3;
  localparam logic [STEP_W-1:0] RD_RIGHT  = 3'd4;
  localparam logic [STEP_W-1:0] RD_FIRST  = 3'd1;

  localparam logic signed [LP_W-1:0] LP_M4 = -4'sd4;
  localparam logic signed [LP_W-1:0] LP_M2 = -4'sd2;
  localparam logic signed [LP_W-1:0] LP_P2 = 4'sd2;
  localparam logic signed [LP_W-1:0] LP_P4 = 4'sd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD_ROW,
    ST_MOD_COL,
    ST_WRAP,
    ST_READ,
    ST_MUL,
    ST_DECIDE,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic              in_ready;
    logic              mod_row;
    logic              mod_col;
    logic              wrap;
    logic              rd;
    logic              mul;
    logic              commit_trial;
    logic              commit_load;
    logic [STEP_W-1:0] step;
  } ctrl_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] cw_m4;
    logic [WEIGHT_W-1:0] cw_m2;
    logic [WEIGHT_W-1:0] cw_z;
    logic [WEIGHT_W-1:0] cw_p2;
    logic [WEIGHT_W-1:0] cw_p4;
    logic [WEIGHT_W-1:0] fw_down;
    logic [WEIGHT_W-1:0] fw_up;
  } weights_t;

endpackage
`default_nettype wire

// ----- sv/ims_ram.sv -----
// Generic single-port RAM with registered read.
`default_nettype none
module ims_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ----- sv/ims_cfg_regs.sv -----
// Configuration registers: lattice side with clamping, coupling and field weights.
`default_nettype none
module ims_cfg_regs #(
  parameter int SIDE = ims_pkg::SIDE_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ims_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ims_pkg::WEIGHT_W-1:0]     cfg_data,
  output logic      [ims_pkg::SIDE_W-1:0]       side_used,
  output ims_pkg::weights_t                     weights
);

  logic [ims_pkg::SIDE_W-1:0] side_r;
  ims_pkg::weights_t          wts_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r        <= ims_pkg::SIDE_RST;
      wts_r.cw_m4   <= ims_pkg::WEIGHT_RST;
      wts_r.cw_m2   <= ims_pkg::WEIGHT_RST;
      wts_r.cw_z    <= ims_pkg::WEIGHT_RST;
      wts_r.cw_p2   <= ims_pkg::WEIGHT_RST;
      wts_r.cw_p4   <= ims_pkg::WEIGHT_RST;
      wts_r.fw_down <= ims_pkg::WEIGHT_RST;
      wts_r.fw_up   <= ims_pkg::WEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ims_pkg::REG_SIDE:  side_r        <= cfg_data[ims_pkg::SIDE_W-1:0];
        ims_pkg::REG_CW_M4: wts_r.cw_m4   <= cfg_data;
        ims_pkg::REG_CW_M2: wts_r.cw_m2   <= cfg_data;
        ims_pkg::REG_CW_Z:  wts_r.cw_z    <= cfg_data;
        ims_pkg::REG_CW_P2: wts_r.cw_p2   <= cfg_data;
        ims_pkg::REG_CW_P4: wts_r.cw_p4   <= cfg_data;
        ims_pkg::REG_FW_DN: wts_r.fw_down <= cfg_data;
        ims_pkg::REG_FW_UP: wts_r.fw_up   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (side_r < ims_pkg::SIDE_MIN) begin
      side_used = ims_pkg::SIDE_MIN;
    end else if (32'(side_r) > SIDE) begin
      side_used = ims_pkg::SIDE_W'(SIDE);
    end else begin
      side_used = side_r;
    end
  end

  assign weights = wts_r;

endmodule
`default_nettype wire

// ----- sv/ims_cmpsub.sv -----
// Shared compare-subtract unit: reduces a value below twice the side into range.
`default_nettype none
module ims_cmpsub (
  input  wire logic [ims_pkg::CRD_W:0]    a,
  input  wire logic [ims_pkg::SIDE_W-1:0] side,
  output logic      [ims_pkg::CRD_W-1:0]  res
);

  logic [ims_pkg::CRD_W:0] side_x;
  logic [ims_pkg::CRD_W:0] diff;

  assign side_x = {1'b0, side};
  assign diff   = a - side_x;
  assign res    = (a >= side_x) ? diff[ims_pkg::CRD_W-1:0] : a[ims_pkg::CRD_W-1:0];

endmodule
`default_nettype wire

// ----- sv/ims_ctrl.sv -----
// Sequencer: steps one load or trial through reduction and commit; a trial also wraps, reads and multiplies.
`default_nettype none
module ims_ctrl (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  input  wire logic   in_op,
  input  wire logic   out_free,
  output ims_pkg::ctrl_t ctrl
);

  ims_pkg::state_t               state_r, state_nxt;
  logic [ims_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic                          op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ims_pkg::ST_IDLE;
      step_r  <= '0;
      op_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r + 3'd1;
    op_nxt    = op_r;
    case (state_r)
      ims_pkg::ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) begin
          state_nxt = ims_pkg::ST_MOD_ROW;
          op_nxt    = in_op;
        end
      end
      ims_pkg::ST_MOD_ROW: begin
        if (step_r == ims_pkg::MOD_LAST) begin
          state_nxt = ims_pkg::ST_MOD_COL;
          step_nxt  = '0;
        end
      end
      ims_pkg::ST_MOD_COL: begin
        if (step_r == ims_pkg::MOD_LAST) begin
          state_nxt = op_r ? ims_pkg::ST_WRAP : ims_pkg::ST_LOAD;
          step_nxt  = '0;
        end
      end
      ims_pkg::ST_WRAP: begin
        if (step_r == ims_pkg::WRAP_LAST) begin
          state_nxt = ims_pkg::ST_READ;
          step_nxt  = '0;
        end
      end
      ims_pkg::ST_READ: begin
        if (step_r == ims_pkg::READ_LAST) begin
          state_nxt = ims_pkg::ST_MUL;
          step_nxt  = '0;
        end
      end
      ims_pkg::ST_MUL: begin
        state_nxt = ims_pkg::ST_DECIDE;
        step_nxt  = '0;
      end
      ims_pkg::ST_DECIDE, ims_pkg::ST_LOAD: begin
        step_nxt = '0;
        if (out_free) begin
          state_nxt = ims_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ims_pkg::ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  always_comb begin
    ctrl              = '0;
    ctrl.step         = step_r;
    case (state_r)
      ims_pkg::ST_IDLE:    ctrl.in_ready     = 1'b1;
      ims_pkg::ST_MOD_ROW: ctrl.mod_row      = 1'b1;
      ims_pkg::ST_MOD_COL: ctrl.mod_col      = 1'b1;
      ims_pkg::ST_WRAP:    ctrl.wrap         = 1'b1;
      ims_pkg::ST_READ:    ctrl.rd           = 1'b1;
      ims_pkg::ST_MUL:     ctrl.mul          = 1'b1;
      ims_pkg::ST_DECIDE:  ctrl.commit_trial = out_free;
      ims_pkg::ST_LOAD:    ctrl.commit_load  = out_free;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/ising_metropolis_spin_update.sv -----
// Top level of the Ising Metropolis single-spin-flip update block.
//
//  channel | ports            | transaction carries
//  --------+------------------+--------------------------------------------------
//  in      | in_t*            | load spin into a site, or Metropolis trial at a site
//  out     | out_t*           | one result per input transaction
//  cfg     | cfg_*            | register write: side, coupling and field weights
//
// One item at a time: a new load or trial is taken only once the last one has
// committed. Row and column are each reduced in six steps of the one
// compare-subtract unit; a trial then wraps four neighbours in four, reads five
// sites through the one RAM port in six, and multiplies the weights in one.
// Reset clears control, the configuration and the magnetization, not the lattice.
// A stalled result holds the next item in its commit state until the register frees.
`default_nettype none
module ising_metropolis_spin_update #(
  parameter int SIDE      = ims_pkg::SIDE_DEF,
  parameter int ROLL_BITS = ims_pkg::ROLL_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // row[5:0], col[11:6], load_spin[12], roll[36:13], zero fill
  input  wire logic [ims_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op
  input  wire logic                              in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // spin_after[0], flipped[1], local_product[5:2], magnetization[19:6], zero fill
  output logic      [ims_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [ims_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ims_pkg::WEIGHT_W-1:0]      cfg_data
);

  localparam int AW = $clog2(SIDE * SIDE);
  localparam logic [AW-1:0] SIDE_A = AW'(SIDE);
  localparam logic [ims_pkg::ROLL_W-1:0] RMASK =
    ims_pkg::ROLL_W'((64'd1 << ROLL_BITS) - 64'd1);

  localparam int CW = ims_pkg::CRD_W;
  localparam int IW = ims_pkg::IN_CRD_W;
  localparam int MW = ims_pkg::MAG_W;
  localparam int LW = ims_pkg::LP_W;
  localparam int PW = ims_pkg::PROD_W;

  ims_pkg::ctrl_t            ctrl;
  ims_pkg::weights_t         weights;
  logic [ims_pkg::SIDE_W-1:0] side_used;
  logic                      out_free;

  // captured input transaction
  logic [IW-1:0]             in_row_r, in_col_r;
  logic                      in_spin_r;
  logic [ims_pkg::ROLL_W-1:0] in_roll_r;

  // reduced coordinates and neighbours
  logic [CW-1:0] row_r, col_r, ru_r, rd_r, cr_r, cl_r;

  logic [CW:0]   cs_a;
  logic [CW-1:0] cs_res;
  logic [2:0]    bit_idx;

  logic [CW-1:0] sel_r, sel_c;
  logic [AW-1:0] addr_rd, addr_c, ram_addr;
  logic          ram_we, ram_wdata, ram_rdata;

  logic                 s_r;
  logic signed [LW-1:0] sum_r, p_c, p_r;
  logic [ims_pkg::WEIGHT_W-1:0] cw_c, fw_c;
  logic [PW-1:0]        w_r;
  logic [31:0]          roll_x;
  logic                 flip, ns;

  logic [MW-1:0]        mag_r, mag_nxt;
  logic                 out_valid_r;
  logic [ims_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  ims_cfg_regs #(.SIDE(SIDE)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .side_used (side_used),
    .weights   (weights)
  );

  ims_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  assign in_tready = ctrl.in_ready;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (in_tvalid && ctrl.in_ready) begin
      in_row_r  <= in_tdata[IW-1:0];
      in_col_r  <= in_tdata[2*IW-1:IW];
      in_spin_r <= in_tdata[2*IW];
      in_roll_r <= in_tdata[2*IW+ims_pkg::ROLL_W:2*IW+1];
    end
  end

  // shared unit operand select
  assign bit_idx = ims_pkg::MOD_LAST - ctrl.step;

  always_comb begin
    cs_a = '0;
    if (ctrl.mod_row) begin
      cs_a = {row_r, in_row_r[bit_idx]};
    end else if (ctrl.mod_col) begin
      cs_a = {col_r, in_col_r[bit_idx]};
    end else begin
      case (ctrl.step)
        ims_pkg::WR_UP:    cs_a = {1'b0, row_r} + 8'd1;
        ims_pkg::WR_DOWN:  cs_a = {1'b0, row_r} + {1'b0, side_used} - 8'd1;
        ims_pkg::WR_RIGHT: cs_a = {1'b0, col_r} + 8'd1;
        ims_pkg::WR_LEFT:  cs_a = {1'b0, col_r} + {1'b0, side_used} - 8'd1;
        default:           cs_a = '0;
      endcase
    end
  end

  ims_cmpsub u_cmpsub (
    .a    (cs_a),
    .side (side_used),
    .res  (cs_res)
  );

  always_ff @(posedge clk) begin
    if (ctrl.in_ready) begin
      row_r <= '0;
      col_r <= '0;
    end else if (ctrl.mod_row) begin
      row_r <= cs_res;
    end else if (ctrl.mod_col) begin
      col_r <= cs_res;
    end
    if (ctrl.wrap) begin
      case (ctrl.step)
        ims_pkg::WR_UP:    ru_r <= cs_res;
        ims_pkg::WR_DOWN:  rd_r <= cs_res;
        ims_pkg::WR_RIGHT: cr_r <= cs_res;
        ims_pkg::WR_LEFT:  cl_r <= cs_res;
        default: ;
      endcase
    end
  end

  // lattice addressing
  always_comb begin
    sel_r = row_r;
    sel_c = col_r;
    case (ctrl.step)
      ims_pkg::RD_UP:    sel_r = ru_r;
      ims_pkg::RD_DOWN:  sel_r = rd_r;
      ims_pkg::RD_LEFT:  sel_c = cl_r;
      ims_pkg::RD_RIGHT: sel_c = cr_r;
      default: ;
    endcase
  end

  assign addr_rd  = AW'(sel_r) * SIDE_A + AW'(sel_c);
  assign addr_c   = AW'(row_r) * SIDE_A + AW'(col_r);
  assign ram_addr = ctrl.rd ? addr_rd : addr_c;
  assign ram_we   = ctrl.commit_load || (ctrl.commit_trial && flip);
  assign ram_wdata = ctrl.commit_load ? in_spin_r : ns;

  ims_ram #(.WIDTH(1), .DEPTH(SIDE * SIDE)) u_lattice (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (ctrl.rd && (ctrl.step == ims_pkg::RD_FIRST)) begin
      s_r   <= ram_rdata;
      sum_r <= '0;
    end else if (ctrl.rd && (ctrl.step > ims_pkg::RD_FIRST)) begin
      sum_r <= sum_r + (ram_rdata ? 4'sd1 : -4'sd1);
    end
  end

  assign p_c = s_r ? sum_r : -sum_r;

  always_comb begin
    case (p_c)
      ims_pkg::LP_M4: cw_c = weights.cw_m4;
      ims_pkg::LP_M2: cw_c = weights.cw_m2;
      ims_pkg::LP_P2: cw_c = weights.cw_p2;
      ims_pkg::LP_P4: cw_c = weights.cw_p4;
      default:        cw_c = weights.cw_z;
    endcase
  end

  assign fw_c = s_r ? weights.fw_up : weights.fw_down;

  always_ff @(posedge clk) begin
    if (ctrl.mul) begin
      p_r <= p_c;
      w_r <= PW'(cw_c) * PW'(fw_c);
    end
  end

  // acceptance: roll / 2^ROLL_BITS < w / 2^32
  assign roll_x = 32'(in_roll_r & RMASK) << (32 - ROLL_BITS);
  assign flip   = (|w_r[PW-1:32]) || (roll_x < w_r[31:0]);
  assign ns     = s_r ^ flip;

  always_comb begin
    mag_nxt      = mag_r;
    out_data_nxt = '0;
    if (ctrl.commit_load) begin
      mag_nxt = in_spin_r ? (mag_r + 14'd1) : (mag_r - 14'd1);
      out_data_nxt[0]          = in_spin_r;
      out_data_nxt[6+MW-1:6]   = mag_nxt;
    end else begin
      if (flip) begin
        mag_nxt = ns ? (mag_r + 14'd2) : (mag_r - 14'd2);
      end
      out_data_nxt[0]          = ns;
      out_data_nxt[1]          = flip;
      out_data_nxt[5:2]        = p_r;
      out_data_nxt[6+MW-1:6]   = mag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.commit_load || ctrl.commit_trial) begin
        mag_r       <= mag_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit_load || ctrl.commit_trial) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// ----- sv/ims_chk.sv -----
// Port-level checker for the spin update block, bound to the top level.
`default_nettype none
module ims_chk (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [ims_pkg::IN_TDATA_W-1:0]    in_tdata,
  input wire logic                              in_tuser,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [ims_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input wire logic                              cfg_valid,
  input wire logic                              cfg_ready,
  input wire logic [ims_pkg::CFG_IDX_W-1:0]     cfg_index,
  input wire logic [ims_pkg::WEIGHT_W-1:0]      cfg_data
);

  // one item at a time: busy straight after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a result only appears while an item is in progress
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result without an item in progress");

  a_lp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:2] == 4'h0 || out_tdata[5:2] == 4'h2 ||
                    out_tdata[5:2] == 4'h4 || out_tdata[5:2] == 4'hE ||
                    out_tdata[5:2] == 4'hC))
    else $error("local product out of range");

endmodule

bind ising_metropolis_spin_update ims_chk u_chk (.*);
`default_nettype wire
